FILE: hw/rtl/mse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_pkg
// shared constants, opcodes and controller/datapath types of the execute block
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
    localparam int          DMEM_WORDS_DEF = 1024;

    localparam logic MODE_EXEC    = 1'b0;
    localparam logic MODE_PRELOAD = 1'b1;

    // primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_BLEZ  = 6'h06;
    localparam logic [5:0] OP_BGTZ  = 6'h07;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    // function codes of r-type
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_DIV     = 6'h1a;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2a;

    localparam logic [4:0] REG_ZERO    = 5'd0;
    localparam logic [4:0] REG_SYSCALL = 5'd2;
    localparam logic [4:0] REG_LINK    = 5'd31;

    typedef enum logic [1:0] {
        MS_CLEAR  = 2'd0,
        MS_DIRECT = 2'd1,
        MS_REM    = 2'd2,
        MS_HELD   = 2'd3
    } t_mem_src;

    typedef struct packed {
        logic     clr_step;
        logic     load_item;
        logic     mem_we;
        logic     div_start;
        logic     div_mod;
        logic     finish;
        t_mem_src mem_src;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_mem;
        logic is_load;
        logic is_div;
        logic div_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic        store_done;
        logic [31:0] store_addr;
        logic [31:0] store_value;
        logic        syscall_req;
        logic [31:0] syscall_code;
        logic        unknown_op;
    } t_result;

endpackage

FILE: hw/rtl/mse_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_in_if / mse_out_if
// request and result channels of the execute block, valid/ready with payload
// ----------------------------------------------------------------------------
interface mse_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] instr;
    logic [9:0]  load_index;
    logic [31:0] load_word;

    modport source (output valid, mode, instr, load_index, load_word, input ready);
    modport sink   (input valid, mode, instr, load_index, load_word, output ready);
endinterface

interface mse_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic        store_done;
    logic [31:0] store_addr;
    logic [31:0] store_value;
    logic        syscall_req;
    logic [31:0] syscall_code;
    logic        unknown_op;

    modport source (output valid, next_pc, reg_written, dest_reg, dest_value, store_done,
                    store_addr, store_value, syscall_req, syscall_code, unknown_op,
                    input ready);
    modport sink   (input valid, next_pc, reg_written, dest_reg, dest_value, store_done,
                    store_addr, store_value, syscall_req, syscall_code, unknown_op,
                    output ready);
endinterface

FILE: hw/rtl/mse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ram
// generic single-write single-read ram with registered read data
// ----------------------------------------------------------------------------
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/mse_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_div
// radix-2 restoring divider, one quotient bit a cycle, signed or unsigned
// ----------------------------------------------------------------------------
module mse_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_signed,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [31:0] o_remainder
);

    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem, r_quo, r_dvs;
    logic        r_neg_q, r_neg_r;

    logic        w_neg_a, w_neg_b;
    logic [32:0] w_shift, w_diff;

    assign w_neg_a = i_signed & i_dividend[31];
    assign w_neg_b = i_signed & i_divisor[31];
    assign w_shift = {r_rem, r_quo[31]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_quo   <= w_neg_a ? (32'd0 - i_dividend) : i_dividend;
            r_dvs   <= w_neg_b ? (32'd0 - i_divisor) : i_divisor;
            r_neg_q <= w_neg_a ^ w_neg_b;
            r_neg_r <= w_neg_a;
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                r_rem <= w_diff[31:0];
            end else begin
                r_rem <= w_shift[31:0];
            end
            r_quo <= {r_quo[30:0], ~w_diff[32]};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_neg_q ? (32'd0 - r_quo) : r_quo;
    assign o_remainder = r_neg_r ? (32'd0 - r_rem) : r_rem;

endmodule

FILE: hw/rtl/mse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_dp
// execute datapath: pc, register file, hi/lo, data memory, result register
// ----------------------------------------------------------------------------
module mse_dp #(
    parameter int DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mse_pkg::t_dp_cmd    i_cmd,
    output mse_pkg::t_dp_status o_status,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data,
    input  logic                i_mode,
    input  logic [31:0]         i_instr,
    input  logic [9:0]          i_load_index,
    input  logic [31:0]         i_load_word,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mse_pkg::t_result    o_result
);

    localparam int AW = $clog2(DMEM_WORDS);

    logic        r_mode;
    logic [31:0] r_instr;
    logic [9:0]  r_load_index;
    logic [31:0] r_load_word;
    logic [31:0] r_pc, r_hi, r_lo;
    logic [31:0] r_gpr_vld;
    logic [AW-1:0] r_clr, r_midx;
    logic        r_out_valid;
    mse_pkg::t_result r_out;

    logic [31:0] w_src_instr;
    logic [4:0]  w_rd_a, w_rd_b, w_lat_a, w_lat_b;
    logic [31:0] w_qa, w_qb, w_a, w_b, w_mem_q;
    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_sa;
    logic [31:0] w_simm, w_pc4, w_btarget, w_jtarget, w_eaddr, w_mod_opnd;
    logic [63:0] w_rot;
    logic signed [63:0] w_prod;
    logic        w_is_mult;
    mse_pkg::t_result w_res;
    logic        w_wr;
    logic [AW-1:0] w_mem_addr;
    logic [31:0] w_mem_wdata;
    logic        w_div_busy, w_div_done;
    logic [31:0] w_quo, w_rem, w_div_a, w_div_b;
    logic        w_out_free;

    // register read addresses follow the incoming item on accept, then hold
    assign w_src_instr = i_cmd.load_item ? i_instr : r_instr;
    assign w_rd_a  = (w_src_instr[31:26] == mse_pkg::OP_RTYPE &&
                      w_src_instr[5:0] == mse_pkg::FN_SYSCALL) ?
                     mse_pkg::REG_SYSCALL : w_src_instr[25:21];
    assign w_rd_b  = w_src_instr[20:16];
    assign w_lat_a = (r_instr[31:26] == mse_pkg::OP_RTYPE &&
                      r_instr[5:0] == mse_pkg::FN_SYSCALL) ?
                     mse_pkg::REG_SYSCALL : r_instr[25:21];
    assign w_lat_b = r_instr[20:16];

    mse_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
        .i_clk  (i_clk),
        .i_we   (i_cmd.finish & w_wr),
        .i_waddr(w_res.dest_reg),
        .i_wdata(w_res.dest_value),
        .i_raddr(w_rd_a),
        .o_rdata(w_qa)
    );

    mse_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
        .i_clk  (i_clk),
        .i_we   (i_cmd.finish & w_wr),
        .i_waddr(w_res.dest_reg),
        .i_wdata(w_res.dest_value),
        .i_raddr(w_rd_b),
        .o_rdata(w_qb)
    );

    // never-written registers read as zero
    assign w_a = r_gpr_vld[w_lat_a] ? w_qa : 32'd0;
    assign w_b = r_gpr_vld[w_lat_b] ? w_qb : 32'd0;

    assign w_op      = r_instr[31:26];
    assign w_fn      = r_instr[5:0];
    assign w_sa      = r_instr[10:6];
    assign w_simm    = {{16{r_instr[15]}}, r_instr[15:0]};
    assign w_pc4     = r_pc + 32'd4;
    assign w_btarget = w_pc4 + {w_simm[29:0], 2'b00};
    assign w_jtarget = {w_pc4[31:28], r_instr[25:0], 2'b00};
    assign w_eaddr   = w_a + w_simm;
    assign w_rot     = {w_b, w_b} >> w_sa;
    assign w_prod    = $signed(w_a) * $signed(w_b);
    assign w_is_mult = (r_mode == mse_pkg::MODE_EXEC) && (w_op == mse_pkg::OP_RTYPE) &&
                       (w_fn == mse_pkg::FN_MULT);

    // word index source before reduction modulo the memory depth
    assign w_mod_opnd = (r_mode == mse_pkg::MODE_PRELOAD) ? {22'd0, r_load_index}
                                                          : {2'b00, w_eaddr[31:2]};

    always_comb begin
        w_res = '0;
        w_res.next_pc = w_pc4;
        if (r_mode == mse_pkg::MODE_PRELOAD) begin
            w_res.next_pc = r_pc;
        end else if (w_op == mse_pkg::OP_RTYPE) begin
            w_res.dest_reg = r_instr[15:11];
            unique case (w_fn)
                mse_pkg::FN_ADD: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = w_a + w_b;
                end
                mse_pkg::FN_SUB: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = w_a - w_b;
                end
                mse_pkg::FN_AND: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = w_a & w_b;
                end
                mse_pkg::FN_OR: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = w_a | w_b;
                end
                mse_pkg::FN_XOR: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = w_a ^ w_b;
                end
                mse_pkg::FN_SLT: begin
                    w_res.reg_written = 1'b1;
                    w_res.dest_value  = {31'd0, $signed(w_a) < $signed(w_b)};
                end
                mse_pkg::FN_SLL: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = w_b << w_sa;
                end
                mse_pkg::FN_SRL: begin
                    w_res.reg_written = 1'b1;
                    w_res.dest_value  = r_instr[21] ? w_rot[31:0] : (w_b >> w_sa);
                end
                mse_pkg::FN_MFHI: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = r_hi;
                end
                mse_pkg::FN_MFLO: begin
                    w_res.reg_written = 1'b1; w_res.dest_value = r_lo;
                end
                mse_pkg::FN_DIV, mse_pkg::FN_MULT: begin
                    w_res.dest_reg = mse_pkg::REG_ZERO;
                end
                mse_pkg::FN_JR: begin
                    w_res.dest_reg = mse_pkg::REG_ZERO;
                    w_res.next_pc  = w_a;
                end
                mse_pkg::FN_SYSCALL: begin
                    w_res.dest_reg     = mse_pkg::REG_ZERO;
                    w_res.syscall_req  = 1'b1;
                    w_res.syscall_code = w_a;
                end
                default: begin
                    w_res.dest_reg   = mse_pkg::REG_ZERO;
                    w_res.unknown_op = 1'b1;
                end
            endcase
        end else begin
            unique case (w_op)
                mse_pkg::OP_ADDI: begin
                    w_res.reg_written = 1'b1; w_res.dest_reg = r_instr[20:16];
                    w_res.dest_value  = w_a + w_simm;
                end
                mse_pkg::OP_ORI: begin
                    w_res.reg_written = 1'b1; w_res.dest_reg = r_instr[20:16];
                    w_res.dest_value  = w_a | {16'd0, r_instr[15:0]};
                end
                mse_pkg::OP_LUI: begin
                    w_res.reg_written = 1'b1; w_res.dest_reg = r_instr[20:16];
                    w_res.dest_value  = {r_instr[15:0], 16'd0};
                end
                mse_pkg::OP_LW: begin
                    w_res.reg_written = 1'b1; w_res.dest_reg = r_instr[20:16];
                    w_res.dest_value  = w_mem_q;
                end
                mse_pkg::OP_SW: begin
                    w_res.store_done  = 1'b1;
                    w_res.store_addr  = w_eaddr;
                    w_res.store_value = w_b;
                end
                mse_pkg::OP_BEQ: begin
                    if (w_a == w_b) w_res.next_pc = w_btarget;
                end
                mse_pkg::OP_BNE: begin
                    if (w_a != w_b) w_res.next_pc = w_btarget;
                end
                mse_pkg::OP_BGTZ: begin
                    if ($signed(w_a) > 0) w_res.next_pc = w_btarget;
                end
                mse_pkg::OP_BLEZ: begin
                    if ($signed(w_a) <= 0) w_res.next_pc = w_btarget;
                end
                mse_pkg::OP_J: begin
                    w_res.next_pc = w_jtarget;
                end
                mse_pkg::OP_JAL: begin
                    w_res.reg_written = 1'b1; w_res.dest_reg = mse_pkg::REG_LINK;
                    w_res.dest_value  = w_pc4;
                    w_res.next_pc     = w_jtarget;
                end
                default: begin
                    w_res.unknown_op = 1'b1;
                end
            endcase
        end
        // writes to register zero are dropped
        if (w_res.dest_reg == mse_pkg::REG_ZERO) begin
            w_res.reg_written = 1'b0;
        end
        if (!w_res.reg_written) begin
            w_res.dest_reg   = mse_pkg::REG_ZERO;
            w_res.dest_value = 32'd0;
        end
    end

    assign w_wr = w_res.reg_written;

    // data memory
    always_comb begin
        case (i_cmd.mem_src)
            mse_pkg::MS_CLEAR:  w_mem_addr = r_clr;
            mse_pkg::MS_DIRECT: w_mem_addr = w_mod_opnd[AW-1:0];
            mse_pkg::MS_REM:    w_mem_addr = w_rem[AW-1:0];
            default:            w_mem_addr = r_midx;
        endcase
    end

    assign w_mem_wdata = (i_cmd.mem_src == mse_pkg::MS_CLEAR) ? 32'd0 :
                         (r_mode == mse_pkg::MODE_PRELOAD) ? r_load_word : w_b;

    mse_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .i_clk  (i_clk),
        .i_we   (i_cmd.mem_we),
        .i_waddr(w_mem_addr),
        .i_wdata(w_mem_wdata),
        .i_raddr(w_mem_addr),
        .o_rdata(w_mem_q)
    );

    // shared divider: signed div, or unsigned word index reduction
    assign w_div_a = i_cmd.div_mod ? w_mod_opnd : w_a;
    assign w_div_b = i_cmd.div_mod ? 32'(DMEM_WORDS) : w_b;

    mse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_signed   (~i_cmd.div_mod),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo),
        .o_remainder(w_rem)
    );

    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode       <= i_mode;
            r_instr      <= i_instr;
            r_load_index <= i_load_index;
            r_load_word  <= i_load_word;
        end
        if (i_cmd.mem_src != mse_pkg::MS_HELD) begin
            r_midx <= w_mem_addr;
        end
        if (i_cmd.finish) begin
            r_out <= w_res;
            if (w_is_mult) begin
                r_hi <= w_prod[63:32];
                r_lo <= w_prod[31:0];
            end else if (o_status.is_div && !o_status.div_zero) begin
                r_hi <= w_rem;
                r_lo <= w_quo;
            end
        end
        if (!i_rst_n) begin
            r_hi <= '0;
            r_lo <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= mse_pkg::START_PC_RESET;
            r_gpr_vld   <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_pc <= i_cfg_wr_data;
            end else if (i_cmd.finish) begin
                r_pc <= w_res.next_pc;
            end
            if (i_cmd.finish && w_wr) begin
                r_gpr_vld[w_res.dest_reg] <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.clr_last = (r_clr == AW'(DMEM_WORDS - 1));
        o_status.is_mem   = (r_mode == mse_pkg::MODE_PRELOAD) ||
                            (w_op == mse_pkg::OP_LW) || (w_op == mse_pkg::OP_SW);
        o_status.is_load  = (r_mode == mse_pkg::MODE_EXEC) && (w_op == mse_pkg::OP_LW);
        o_status.is_div   = (r_mode == mse_pkg::MODE_EXEC) &&
                            (w_op == mse_pkg::OP_RTYPE) && (w_fn == mse_pkg::FN_DIV);
        o_status.div_zero = (w_b == 32'd0);
        o_status.div_done = w_div_done;
        o_status.out_free = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> w_out_free)
        else $error("result register overwritten before it was taken");

    a_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_gpr_vld[0])
        else $error("register zero was written");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !w_div_busy)
        else $error("divider restarted while busy");

endmodule

FILE: hw/rtl/mse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mse_ctrl
// sequencer for the execute datapath: memory clear, issue, memory and divide
// ----------------------------------------------------------------------------
module mse_ctrl #(
    parameter int DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mse_pkg::t_dp_status i_status,
    output mse_pkg::t_dp_cmd    o_cmd
);

    localparam bit IS_POW2 = (DMEM_WORDS & (DMEM_WORDS - 1)) == 0;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_EXEC  = 7'b0000100,
        ST_MOD   = 7'b0001000,
        ST_MEMOP = 7'b0010000,
        ST_LOAD  = 7'b0100000,
        ST_DIVW  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mem_src = mse_pkg::MS_HELD;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.mem_src  = mse_pkg::MS_CLEAR;
                o_cmd.mem_we   = 1'b1;
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_div && !i_status.div_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIVW;
                end else if (i_status.is_mem && !IS_POW2) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_mod   = 1'b1;
                    n_state         = ST_MOD;
                end else if (i_status.is_mem && i_status.is_load) begin
                    o_cmd.mem_src = mse_pkg::MS_DIRECT;
                    n_state       = ST_LOAD;
                end else begin
                    if (i_status.is_mem) o_cmd.mem_src = mse_pkg::MS_DIRECT;
                    if (i_status.out_free) begin
                        o_cmd.mem_we = i_status.is_mem;
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_MOD: begin
                if (i_status.div_done) n_state = ST_MEMOP;
            end
            ST_MEMOP: begin
                o_cmd.mem_src = mse_pkg::MS_REM;
                if (i_status.is_load) begin
                    n_state = ST_LOAD;
                end else if (i_status.out_free) begin
                    o_cmd.mem_we = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_DIVW: begin
                if (i_status.div_done && i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    a_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |=> (r_state == ST_EXEC))
        else $error("accepted request did not move to execute");

endmodule

FILE: hw/rtl/mips_subset_execute.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_subset_execute
// executes one mips32 subset instruction or one memory preload per request
// ----------------------------------------------------------------------------
// sequence: a request passes the execute state into the result register; lw with a
//   power-of-two memory depth adds a load state; div by a nonzero divisor waits on
//   the serial divider; memory depths other than a power of two reduce the word
//   index on the same divider before lw, sw and preload access data memory
// throughput: one request at a time; a new one is taken while the result waits
// reset (synchronous, low): pc to 0x00400000, registers, hi and lo to zero,
//   then a clear sweep zeroes every data memory word before accept
// ----------------------------------------------------------------------------
module mips_subset_execute #(
    parameter int DMEM_WORDS = mse_pkg::DMEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    mse_in_if.sink      i_in,
    mse_out_if.source   o_out
);

    // command and status between sequencer and datapath
    mse_pkg::t_dp_cmd    w_cmd;
    mse_pkg::t_dp_status w_status;
    mse_pkg::t_result    w_result;
    logic                w_in_ready;
    logic                w_out_valid;

    // sequencer: clear sweep, issue, memory access and divide waits
    mse_ctrl #(.DMEM_WORDS(DMEM_WORDS)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    // datapath: architectural state and the result register
    mse_dp #(.DMEM_WORDS(DMEM_WORDS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_mode       (i_in.mode),
        .i_instr      (i_in.instr),
        .i_load_index (i_in.load_index),
        .i_load_word  (i_in.load_word),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (w_out_valid),
        .o_result     (w_result)
    );

    assign i_in.ready = w_in_ready;

    // result register drives the output channel directly
    assign o_out.valid        = w_out_valid;
    assign o_out.next_pc      = w_result.next_pc;
    assign o_out.reg_written  = w_result.reg_written;
    assign o_out.dest_reg     = w_result.dest_reg;
    assign o_out.dest_value   = w_result.dest_value;
    assign o_out.store_done   = w_result.store_done;
    assign o_out.store_addr   = w_result.store_addr;
    assign o_out.store_value  = w_result.store_value;
    assign o_out.syscall_req  = w_result.syscall_req;
    assign o_out.syscall_code = w_result.syscall_code;
    assign o_out.unknown_op   = w_result.unknown_op;

endmodule
